FILE: sv/rbc_pkg.sv
`timescale 1ns / 1ps

package rbc_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned RANK_W   = 6;
  localparam int unsigned RANK_MAX = 63;

  // out tdata: rank, overflow, zero fill to a whole byte
  localparam int unsigned OUT_DATA_W = 8;

endpackage

FILE: sv/rbc_cell.sv
`timescale 1ns / 1ps

module rbc_cell #(
  parameter int unsigned CNT_W = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item travelling down the chain
  input  logic                        probe_valid_i,
  input  logic signed [31:0]          probe_value_i,
  input  logic        [CNT_W-1:0]     probe_cnt_i,
  output logic                        probe_valid_o,
  output logic signed [31:0]          probe_value_o,
  output logic        [CNT_W-1:0]     probe_cnt_o,
  // drain shift towards cell 0
  input  logic                        shift_i,
  input  logic                        next_occ_i,
  input  logic        [CNT_W-1:0]     next_cnt_i,
  output logic                        occ_o,
  output logic        [CNT_W-1:0]     cnt_o
);

  import rbc_pkg::*;

  logic                     occ_q, occ_d;
  logic signed [VALUE_W-1:0] value_q, value_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic                     pv_q, pv_d;
  logic signed [VALUE_W-1:0] pval_q, pval_d;
  logic [CNT_W-1:0]         pcnt_q, pcnt_d;
  logic                     probe_lt;   // travelling item below held value
  logic                     held_lt;    // held value below travelling item

  assign probe_lt = probe_value_i < value_q;
  assign held_lt  = value_q < probe_value_i;

  always_comb begin
    occ_d   = occ_q;
    value_d = value_q;
    cnt_d   = cnt_q;
    pv_d    = 1'b0;
    pval_d  = probe_value_i;
    pcnt_d  = probe_cnt_i;
    if (shift_i) begin
      occ_d = next_occ_i;
      cnt_d = next_cnt_i;
    end else if (probe_valid_i) begin
      if (occ_q) begin
        // held entry is older: count both ways and pass the item on
        cnt_d  = cnt_q + CNT_W'(probe_lt);
        pv_d   = 1'b1;
        pcnt_d = probe_cnt_i + CNT_W'(held_lt);
      end else begin
        // first free cell: the item settles here
        occ_d   = 1'b1;
        value_d = probe_value_i;
        cnt_d   = probe_cnt_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      pv_q  <= 1'b0;
    end else begin
      occ_q <= occ_d;
      pv_q  <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    cnt_q   <= cnt_d;
    pval_q  <= pval_d;
    pcnt_q  <= pcnt_d;
  end

  assign probe_valid_o = pv_q;
  assign probe_value_o = pval_q;
  assign probe_cnt_o   = pcnt_q;
  assign occ_o         = occ_q;
  assign cnt_o         = cnt_q;

endmodule

FILE: sv/rank_by_comparison_count.sv
`timescale 1ns / 1ps
// channel   | dir | handshake               | tdata (low bit up)              | tlast
// ----------+-----+-------------------------+---------------------------------+---------
// s_axis    | in  | s_axis_tvalid/_tready   | [31:0] sample_value             | last_in
// m_axis    | out | m_axis_tvalid/_tready   | [5:0] rank, [6] overflow, [7] 0 | last_out
//
// while collecting, one item per cycle is taken; each item walks the cell chain one cell
// per cycle, counting against every older held value, and settles in the first free cell.
// after the last item the block waits in settle until no item is walking; then results leave from
// cell 0 at one per cycle while m_axis_tready is high, as the chain shifts down.
// the input is stalled from the last item until the final result is taken.
// reset clears occupancy, travelling items, fill count, overflow and state.

module rank_by_comparison_count #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [rbc_pkg::VALUE_W-1:0]       s_axis_tdata,   // [31:0] sample_value
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [rbc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,   // [5:0] rank, [6] overflow, [7] 0
  output logic                              m_axis_tlast
);

  import rbc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS);
  localparam int unsigned FILL_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned EXT_W  = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_SETTLE  = 3'b010,
    ST_DRAIN   = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic               ovf_q, ovf_d;

  logic               in_acc, out_acc, has_room, shift, chain_busy;
  logic [MAX_ITEMS:0] pv;
  logic signed [VALUE_W-1:0] pval [MAX_ITEMS+1];
  logic [CNT_W-1:0]   pcnt [MAX_ITEMS+1];
  logic [MAX_ITEMS:0] occ;
  logic [CNT_W-1:0]   cnt [MAX_ITEMS+1];
  logic [EXT_W-1:0]   head_cnt;
  logic [RANK_W-1:0]  rank;

  assign s_axis_tready = state_q == ST_COLLECT;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = state_q == ST_DRAIN;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign has_room      = fill_q != FILL_W'(MAX_ITEMS);
  assign shift         = out_acc;

  assign pv[0]   = in_acc && has_room;
  assign pval[0] = $signed(s_axis_tdata);
  assign pcnt[0] = '0;
  // nothing beyond the last cell
  assign occ[MAX_ITEMS] = 1'b0;
  assign cnt[MAX_ITEMS] = '0;

  genvar k;
  generate
    for (k = 0; k < MAX_ITEMS; k++) begin : g_cell
      rbc_cell #(
        .CNT_W(CNT_W)
      ) u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .probe_valid_i(pv[k]),
        .probe_value_i(pval[k]),
        .probe_cnt_i  (pcnt[k]),
        .probe_valid_o(pv[k+1]),
        .probe_value_o(pval[k+1]),
        .probe_cnt_o  (pcnt[k+1]),
        .shift_i      (shift),
        .next_occ_i   (occ[k+1]),
        .next_cnt_i   (cnt[k+1]),
        .occ_o        (occ[k]),
        .cnt_o        (cnt[k])
      );
    end
  endgenerate

  assign chain_busy = |pv[MAX_ITEMS:1];

  assign head_cnt = EXT_W'(cnt[0]);
  assign rank     = (head_cnt > EXT_W'(RANK_MAX)) ? RANK_W'(RANK_MAX) : head_cnt[RANK_W-1:0];

  assign m_axis_tdata = {1'b0, ovf_q, rank};
  assign m_axis_tlast = fill_q == FILL_W'(1);

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_acc) begin
          if (has_room) begin
            fill_d = fill_q + FILL_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = ST_SETTLE;
          end
        end
      end
      ST_SETTLE: begin
        if (!chain_busy) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          fill_d = fill_q - FILL_W'(1);
          if (fill_q == FILL_W'(1)) begin
            ovf_d   = 1'b0;
            state_d = ST_COLLECT;
          end
        end
      end
      default: begin
        state_d = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_COLLECT;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(MAX_ITEMS))
    else $error("fill count beyond capacity");

  a_head_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> occ[0] && !chain_busy)
    else $error("result shown from an empty or unsettled chain");

  a_drain_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast) |=> (fill_q == '0) && !ovf_q && !occ[0] && s_axis_tready)
    else $error("store not empty after the final result");

  a_no_walk_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SETTLE) && !chain_busy |=> !chain_busy)
    else $error("item still walking after the chain settled");

endmodule
